[sv/bmot_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmot_pkg
// Shared types and constants for the button multi-click override timer:
// item layouts, configuration layout, mode, event and register codes.
// ----------------------------------------------------------------------------
package bmot_pkg;

	localparam int NOW_BITS = 32;
	localparam int DEB_BITS = 16;
	localparam int WIN_BITS = 16;
	localparam int LIM_BITS = 4;
	localparam int MIN_BITS = 10;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	// Operation modes of an input item.
	localparam logic [1:0] MODE_POLL = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_SET  = 2'd2;

	// Event codes.
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_SHORT = 2'd1;
	localparam logic [1:0] EV_MULTI = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_TIME   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLICK_WINDOW    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLICK_LIMIT     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_OVERRIDE_LENGTH = 3'd3;

	// Configuration reset values.
	localparam logic [DEB_BITS-1:0] DEBOUNCE_TIME_RST   = 16'd50;
	localparam logic [WIN_BITS-1:0] CLICK_WINDOW_RST    = 16'd2000;
	localparam logic [LIM_BITS-1:0] CLICK_LIMIT_RST     = 4'd5;
	localparam logic [MIN_BITS-1:0] OVERRIDE_LENGTH_RST = 10'd120;

	typedef struct packed {
		logic [1:0]          mode;
		logic                pin_level;
		logic [NOW_BITS-1:0] now_time;
		logic                override_on;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          event_res;
		logic                override_active;
		logic [MIN_BITS-1:0] minutes_left;
		logic                clear_fan_target;
	} out_item_t;

	typedef struct packed {
		logic [DEB_BITS-1:0] debounce_time;
		logic [WIN_BITS-1:0] click_window;
		logic [LIM_BITS-1:0] click_limit;
		logic [MIN_BITS-1:0] override_length;
	} cfg_t;

endpackage
`default_nettype wire

[sv/bmot_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmot_cfg_regs
// Configuration register file. Takes indexed writes and presents the
// register set as one struct; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bmot_cfg_regs (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [bmot_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [bmot_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output bmot_pkg::cfg_t                            cfg
);
	import bmot_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= DEBOUNCE_TIME_RST;
			cfg_q.click_window    <= CLICK_WINDOW_RST;
			cfg_q.click_limit     <= CLICK_LIMIT_RST;
			cfg_q.override_length <= OVERRIDE_LENGTH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE_TIME: begin
					cfg_q.debounce_time <= cfg_data[DEB_BITS-1:0];
				end
				REG_CLICK_WINDOW: begin
					cfg_q.click_window <= cfg_data[WIN_BITS-1:0];
				end
				REG_CLICK_LIMIT: begin
					cfg_q.click_limit <= cfg_data[LIM_BITS-1:0];
				end
				REG_OVERRIDE_LENGTH: begin
					cfg_q.override_length <= cfg_data[MIN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/button_multiclick_override_timer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// button_multiclick_override_timer_core
// Debounced active-low button with click counting, multi-press detection
// and a minute-based manual override countdown.
// ----------------------------------------------------------------------------
// Every input item yields exactly one result item. The block takes one item
// per clock while the output is not stalled: an item is registered on entry,
// evaluated against the state by combinational compare-and-update logic, and
// its result is registered on the way out into the output register, where it
// is taken when the output is not stalled. A stalled result holds in the
// output register while one further item may still be taken into the input
// register.
// Timestamps and debounce arithmetic are TIME_BITS wide; now_time is
// zero-extended or truncated to that width. Configuration writes are always
// accepted and take effect on the next item evaluated.
module button_multiclick_override_timer_core #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire bmot_pkg::in_item_t                   item,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output bmot_pkg::out_item_t                       result,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [bmot_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [bmot_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import bmot_pkg::*;

	cfg_t cfg;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_s2;
	logic      valid_s2;
	logic      advance;

	logic                 stable_level_q;
	logic [TIME_BITS-1:0] edge_stamp_q;
	logic [LIM_BITS-1:0]  press_count_q;
	logic [TIME_BITS-1:0] window_start_q;
	logic                 short_pending_q;
	logic                 override_flag_q;
	logic [MIN_BITS-1:0]  override_count_q;

	logic                 stable_level_d;
	logic [TIME_BITS-1:0] edge_stamp_d;
	logic [LIM_BITS-1:0]  press_count_d;
	logic [TIME_BITS-1:0] window_start_d;
	logic                 short_pending_d;
	logic                 override_flag_d;
	logic [MIN_BITS-1:0]  override_count_d;
	out_item_t            result_d;

	logic [TIME_BITS-1:0] now_t;

	bmot_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	generate
		if (TIME_BITS > NOW_BITS) begin : g_now_ext
			assign now_t = {{(TIME_BITS-NOW_BITS){1'b0}}, item_s1.now_time};
		end else begin : g_now_trunc
			assign now_t = item_s1.now_time[TIME_BITS-1:0];
		end
	endgenerate

	// Both stages move together unless a finished result is held by the sink, when only an empty input stage fills.
	assign advance      = !(valid_s2 && result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_comb begin
		logic [LIM_BITS-1:0]  lim;
		logic                 taken;
		logic                 press;
		logic [LIM_BITS-1:0]  pc1;
		logic [TIME_BITS-1:0] since_edge;
		logic [TIME_BITS-1:0] since_start;
		logic                 expire;
		logic                 multi;
		logic                 pend;

		stable_level_d   = stable_level_q;
		edge_stamp_d     = edge_stamp_q;
		press_count_d    = press_count_q;
		window_start_d   = window_start_q;
		short_pending_d  = short_pending_q;
		override_flag_d  = override_flag_q;
		override_count_d = override_count_q;
		result_d.event_res        = EV_NONE;
		result_d.clear_fan_target = 1'b0;

		lim = (cfg.click_limit == '0) ? LIM_BITS'(1) : cfg.click_limit;
		since_edge = now_t - edge_stamp_q;
		taken = (item_s1.pin_level != stable_level_q) &&
			(since_edge > TIME_BITS'(cfg.debounce_time));
		press = taken && !item_s1.pin_level;
		pc1 = press ? press_count_q + LIM_BITS'(1) : press_count_q;
		since_start = (press && (press_count_q == '0)) ?
			'0 : now_t - window_start_q;
		expire = (pc1 != '0) && (since_start >= TIME_BITS'(cfg.click_window));
		// Reaching the limit wins whether or not the window has also run out.
		multi = (pc1 >= lim);
		pend = short_pending_q || (expire && !multi);

		case (item_s1.mode)
			MODE_POLL: begin
				if (taken) begin
					stable_level_d = item_s1.pin_level;
					edge_stamp_d   = now_t;
				end
				if (press && (press_count_q == '0)) begin
					window_start_d = now_t;
				end
				press_count_d = (expire || multi) ? '0 : pc1;
				if (multi) begin
					result_d.event_res = EV_MULTI;
					override_flag_d    = 1'b0;
					override_count_d   = '0;
					short_pending_d    = pend;
				end else begin
					result_d.event_res = pend ? EV_SHORT : EV_NONE;
					short_pending_d    = 1'b0;
				end
			end
			MODE_TICK: begin
				if (override_flag_q && (override_count_q != '0)) begin
					override_count_d = override_count_q - MIN_BITS'(1);
					if (override_count_q == MIN_BITS'(1)) begin
						override_flag_d           = 1'b0;
						result_d.clear_fan_target = 1'b1;
					end
				end
			end
			MODE_SET: begin
				override_flag_d  = item_s1.override_on;
				override_count_d = item_s1.override_on ? cfg.override_length : '0;
			end
			default: begin
			end
		endcase

		result_d.override_active = override_flag_d;
		result_d.minutes_left    = override_count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			stable_level_q   <= 1'b1;
			edge_stamp_q     <= '0;
			press_count_q    <= '0;
			window_start_q   <= '0;
			short_pending_q  <= 1'b0;
			override_flag_q  <= 1'b0;
			override_count_q <= '0;
		end else if (advance) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				stable_level_q   <= stable_level_d;
				edge_stamp_q     <= edge_stamp_d;
				press_count_q    <= press_count_d;
				window_start_q   <= window_start_d;
				short_pending_q  <= short_pending_d;
				override_flag_q  <= override_flag_d;
				override_count_q <= override_count_d;
			end
		end else if (!valid_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance && valid_s1) begin
			result_s2 <= result_d;
		end
	end

endmodule
`default_nettype wire

[bench/tb_button_multiclick_override_timer_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_multiclick_override_timer_core
// Self-checking bench for the button multi-click override timer. A directed
// run covers the field extremes, every mode and the corner cases of click
// counting and the override countdown. Randomized bursts of pin polls,
// minute ticks and override commands follow under several register settings.
// Each accepted item is run through a behavioral copy of the block, and each
// result item is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_button_multiclick_override_timer_core;
	import bmot_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd5;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 125;

	// Predicts the result of every accepted item and checks the block's output.
	class click_tracker;
		logic [DEB_BITS-1:0] debounce_ms;
		logic [WIN_BITS-1:0] window_ms;
		logic [LIM_BITS-1:0] click_cap;
		logic [MIN_BITS-1:0] hold_length;

		logic                settled_pin;
		logic [NOW_BITS-1:0] last_edge_ms;
		logic [LIM_BITS-1:0] clicks;
		logic [NOW_BITS-1:0] burst_start_ms;
		logic                short_owed;
		logic                hold_on;
		logic [MIN_BITS-1:0] hold_minutes;

		out_item_t expected_results[$];
		int errors;

		function new();
			debounce_ms = DEBOUNCE_TIME_RST;
			window_ms = CLICK_WINDOW_RST;
			click_cap = CLICK_LIMIT_RST;
			hold_length = OVERRIDE_LENGTH_RST;
			settled_pin = 1'b1;
			last_edge_ms = '0;
			clicks = '0;
			burst_start_ms = '0;
			short_owed = 1'b0;
			hold_on = 1'b0;
			hold_minutes = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_DEBOUNCE_TIME: debounce_ms = data[DEB_BITS-1:0];
				REG_CLICK_WINDOW: window_ms = data[WIN_BITS-1:0];
				REG_CLICK_LIMIT: click_cap = data[LIM_BITS-1:0];
				REG_OVERRIDE_LENGTH: hold_length = data[MIN_BITS-1:0];
				default: ;
			endcase
		endfunction

		function void drop_override();
			hold_on = 1'b0;
			hold_minutes = '0;
		endfunction

		function logic [1:0] poll(logic pin, logic [NOW_BITS-1:0] now);
			logic [1:0] ev;
			logic [LIM_BITS-1:0] cap;
			logic [NOW_BITS-1:0] since;
			ev = EV_NONE;
			cap = (click_cap == 0) ? 4'd1 : click_cap;
			if (pin != settled_pin) begin
				since = now - last_edge_ms;
				if (since > NOW_BITS'(debounce_ms)) begin
					last_edge_ms = now;
					settled_pin = pin;
					if (!pin) begin
						if (clicks == 0)
							burst_start_ms = now;
						clicks = clicks + 1'b1;
					end
				end
			end
			since = now - burst_start_ms;
			if (clicks != 0 && since >= NOW_BITS'(window_ms)) begin
				// A burst judged at window expiry can still hold a full count
				// when the limit was lowered while it was open.
				if (clicks >= cap) begin
					ev = EV_MULTI;
					drop_override();
				end else begin
					short_owed = 1'b1;
				end
				clicks = '0;
			end
			if (clicks >= cap) begin
				ev = EV_MULTI;
				drop_override();
				clicks = '0;
			end
			if (short_owed && ev == EV_NONE) begin
				ev = EV_SHORT;
				short_owed = 1'b0;
			end
			return ev;
		endfunction

		function void take_item(in_item_t x);
			out_item_t r;
			r = '0;
			case (x.mode)
				MODE_POLL: r.event_res = poll(x.pin_level, x.now_time);
				MODE_TICK: begin
					// A zero countdown never expires on a tick.
					if (hold_on && hold_minutes != 0) begin
						hold_minutes = hold_minutes - 1'b1;
						if (hold_minutes == 0) begin
							hold_on = 1'b0;
							r.clear_fan_target = 1'b1;
						end
					end
				end
				MODE_SET: begin
					hold_on = x.override_on;
					hold_minutes = x.override_on ? hold_length : '0;
				end
				default: ;
			endcase
			r.override_active = hold_on;
			r.minutes_left = hold_minutes;
			expected_results.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] expv, logic [31:0] act);
			if (act !== expv) begin
				$error("%s: expected %0d, got %0d", field, expv, act);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				$error("result item with no item outstanding");
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare("event_res", 32'(want.event_res), 32'(got.event_res));
			compare("override_active", 32'(want.override_active),
				32'(got.override_active));
			compare("minutes_left", 32'(want.minutes_left), 32'(got.minutes_left));
			compare("clear_fan_target", 32'(want.clear_fan_target),
				32'(got.clear_fan_target));
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_item_t item;
	logic result_valid;
	logic result_stall;
	out_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	click_tracker board;
	bit calm;
	bit hold_req;
	int quiet_cycles;

	// Stimulus-side view of time, pin and the current settings.
	logic [NOW_BITS-1:0] poll_ms;
	logic last_pin;
	logic [DEB_BITS-1:0] deb_cfg;
	logic [WIN_BITS-1:0] win_cfg;

	button_multiclick_override_timer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, calm stretches, and one long hold-off on request.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_stall <= !calm && ($urandom_range(99) < 13);
			end
		end
	end

	always @(posedge clk) begin
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				board.take_item(item);
				moved = 1'b1;
			end
			if (result_valid && !result_stall) begin
				board.check_result(result);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready)
				moved = 1'b1;
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("button_multiclick_override_timer_core test failed");
		$finish;
	end

	task automatic send_item(in_item_t x);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 13) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, value);
	endtask

	// Upper data bits beyond a register's width are filled at random.
	task automatic write_config(logic [DEB_BITS-1:0] deb, logic [WIN_BITS-1:0] win,
			logic [LIM_BITS-1:0] lim, logic [MIN_BITS-1:0] len);
		write_reg(REG_DEBOUNCE_TIME, deb);
		write_reg(REG_CLICK_WINDOW, win);
		write_reg(REG_CLICK_LIMIT, {12'($urandom_range(4095)), lim});
		write_reg(REG_OVERRIDE_LENGTH, {6'($urandom_range(63)), len});
		@(negedge clk);
		cfg_valid <= 1'b0;
		deb_cfg = deb;
		win_cfg = win;
	endtask

	// Wait for every outstanding result before touching the registers.
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic in_item_t poll_at(logic pin, logic [NOW_BITS-1:0] ms);
		in_item_t x;
		x.mode = MODE_POLL;
		x.pin_level = pin;
		x.now_time = ms;
		x.override_on = 1'($urandom_range(1));
		return x;
	endfunction

	function automatic in_item_t command(logic [1:0] mode, logic arm);
		in_item_t x;
		x.mode = mode;
		x.pin_level = 1'($urandom_range(1));
		x.now_time = $urandom();
		x.override_on = arm;
		return x;
	endfunction

	function automatic in_item_t random_item();
		logic [NOW_BITS-1:0] step;
		int pick;
		pick = $urandom_range(99);
		if (pick >= 80) begin
			if (pick < 89)
				return command(MODE_TICK, 1'($urandom_range(1)));
			if (pick < 97)
				return command(MODE_SET, $urandom_range(9) < 6);
			return command(MODE_UNUSED, 1'($urandom_range(1)));
		end
		// Steps cluster around the debounce time so that bursts of clicks
		// land inside the window; a few jump far or wrap the timestamp.
		case ($urandom_range(11))
			0: step = '0;
			1, 2, 3, 4: step = NOW_BITS'(deb_cfg) + $urandom_range(3, 1);
			5: step = NOW_BITS'(deb_cfg);
			6: step = $urandom_range(deb_cfg, 0);
			7: step = NOW_BITS'(win_cfg);
			8: step = $urandom_range(2 * win_cfg + 1, 1);
			9: step = $urandom();
			default: step = $urandom_range(20, 1);
		endcase
		poll_ms = poll_ms + step;
		if ($urandom_range(3) != 0)
			last_pin = ~last_pin;
		return poll_at(last_pin, poll_ms);
	endfunction

	initial begin
		logic [DEB_BITS-1:0] deb;
		logic [WIN_BITS-1:0] win;
		logic [LIM_BITS-1:0] lim;
		logic [MIN_BITS-1:0] len;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEBOUNCE_TIME;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		poll_ms = '0;
		last_pin = 1'b1;
		deb_cfg = DEBOUNCE_TIME_RST;
		win_cfg = CLICK_WINDOW_RST;
		board = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: unused mode, idle tick, arm and count, debounce
		// boundary, a short press and a burst across the timestamp wrap.
		send_item(command(MODE_UNUSED, 1'b1));
		send_item(command(MODE_TICK, 1'b1));
		send_item(command(MODE_SET, 1'b1));
		send_item(command(MODE_TICK, 1'b0));
		send_item(poll_at(1'b0, 32'd0));
		send_item(poll_at(1'b0, 32'd51));
		send_item(poll_at(1'b1, 32'd101));
		send_item(poll_at(1'b1, 32'd102));
		send_item(poll_at(1'b1, 32'd2051));
		send_item(command(MODE_SET, 1'b0));
		send_item(poll_at(1'b0, 32'hFFFF_FFFF));
		send_item(poll_at(1'b1, 32'h0000_0040));
		send_item(poll_at(1'b0, 32'h0000_0080));
		settle();

		// Zero limit and zero window: the open burst expires with a full count,
		// and a zero-minute override holds through ticks until a multi-press.
		write_config(16'd0, 16'd0, 4'd0, 10'd0);
		send_item(poll_at(1'b0, 32'h0000_0090));
		send_item(command(MODE_SET, 1'b1));
		send_item(command(MODE_TICK, 1'b1));
		send_item(poll_at(1'b1, 32'h0000_0091));
		send_item(poll_at(1'b0, 32'h0000_0092));
		settle();

		// Zero window with a limit of two gives a short press on the same poll.
		write_config(16'd0, 16'd0, 4'd2, 10'd1023);
		send_item(poll_at(1'b1, 32'h0000_0093));
		send_item(poll_at(1'b0, 32'h0000_0094));
		send_item(command(MODE_SET, 1'b1));
		send_item(command(MODE_TICK, 1'b0));
		settle();

		// Largest settings; a one-minute override expires on the next tick.
		write_config(16'hFFFF, 16'hFFFF, 4'd15, 10'd1);
		send_item(command(MODE_SET, 1'b1));
		send_item(command(MODE_TICK, 1'b0));
		send_item(poll_at(1'b1, 32'h0000_0094 + 32'h0000_FFFF));
		send_item(poll_at(1'b1, 32'h0000_0094 + 32'h0001_0000));
		settle();
		poll_ms = 32'h0001_0094;
		last_pin = 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(9))
				0: deb = '0;
				1: deb = 16'hFFFF;
				default: deb = 16'($urandom_range(30));
			endcase
			case ($urandom_range(9))
				0: win = '0;
				1: win = 16'hFFFF;
				2: win = 16'd1;
				default: win = 16'($urandom_range(400, 20));
			endcase
			lim = ($urandom_range(9) < 3) ? 4'($urandom_range(15)) : 4'($urandom_range(6, 1));
			case ($urandom_range(9))
				0: len = '0;
				1: len = 10'd1023;
				default: len = 10'($urandom_range(8, 1));
			endcase
			if (p == 2)
				write_reg(REG_UNUSED, 16'($urandom()));
			write_config(deb, win, lim, len);
			calm = (p == 3);
			if (p == 5)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(random_item());
			settle();
		end
		calm = 1'b0;

		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("button_multiclick_override_timer_core test passed");
		else
			$display("button_multiclick_override_timer_core test failed");
		$finish;
	end

endmodule

[files.f]
sv/bmot_pkg.sv
sv/bmot_cfg_regs.sv
sv/button_multiclick_override_timer_core.sv
bench/tb_button_multiclick_override_timer_core.sv
